/* rtl/core/assert_macros.svh */
// Assertion macros shared by the cache RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/lkv_pkg.sv */
// Shared types and constants for the LFU key/value cache.
// Depends on nothing; used by the controller, the datapath and the top level.
package lkv_pkg;

	localparam int DEFAULT_ENTRIES = 16;
	localparam int CAP_W           = 5;
	localparam int KEY_W           = 32;
	localparam int VALUE_W         = 32;
	localparam int COUNT_W         = 32;
	localparam int STAMP_W         = 48;

	localparam logic [CAP_W-1:0]   CAP_RESET  = 5'd16;
	localparam logic [COUNT_W-1:0] COUNT_MAX  = 32'hFFFF_FFFF;
	localparam logic [VALUE_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

	// Request kinds.
	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	// One request item.
	typedef struct packed {
		logic                      op;
		logic signed [KEY_W-1:0]   lookup_key;
		logic signed [VALUE_W-1:0] write_value;
	} req_t;

	// One result item.
	typedef struct packed {
		logic                      hit;
		logic signed [VALUE_W-1:0] read_value;
	} rsp_t;

	// One stored cache entry.
	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
		logic [COUNT_W-1:0] count;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic commit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_done;
		logic is_get;
	} status_t;

endpackage

/* rtl/core/lfu_key_value_cache.sv */
// LFU key/value cache with least-recent-use tie break, top level.
// Each item is accepted, then the entry memory is scanned through its single read port, and then
// the item commits; a get commit waits while a held result is stalled. No new item is taken before commit.
// A get gives a result from its commit; a put gives no result.
// Reset (arst_n, asynchronous, active low) clears all valid bits and the stamp clock
// and sets the capacity to 16; entry contents are not cleared.
`include "assert_macros.svh"

module lfu_key_value_cache #(
	parameter int ENTRIES = lkv_pkg::DEFAULT_ENTRIES
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  lkv_pkg::req_t             req,
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output lkv_pkg::rsp_t             rsp,
	input  logic                      cfg_wr_en,
	input  logic [lkv_pkg::CAP_W-1:0] cfg_wr_data
);

	lkv_pkg::cmd_t    cmd;
	lkv_pkg::status_t status;

	// Sequencing of accept, scan and commit.
	lkv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// Entry storage, search and update.
	lkv_datapath #(
		.ENTRIES (ENTRIES)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req),
		.rsp         (rsp),
		.cmd         (cmd),
		.status      (status)
	);

	// The block takes no second item until the current one has committed.
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req_valid && !req_stall, req_stall, "item accepted while busy")
	// A new result only ever follows a commit.
	`ASSERT_SAME(a_rsp_after_commit, clk, arst_n, $rose(rsp_valid), $past(cmd.commit), "result without commit")
	// A put commit never raises a result.
	`ASSERT_NEXT(a_put_no_rsp, clk, arst_n, cmd.commit && !status.is_get, !$rose(rsp_valid), "put produced a result")

endmodule

/* rtl/core/lkv_ctrl.sv */
// Controller state machine of the LFU key/value cache.
// Depends on lkv_pkg; drives commands to lkv_datapath and the channel handshakes.
module lkv_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	input  lkv_pkg::status_t status,
	output lkv_pkg::cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;

	// A get may only commit once the result register is free or being emptied.
	always_comb begin
		req_stall   = (state_q != ST_IDLE);
		cmd.capture = (state_q == ST_IDLE) && req_valid;
		cmd.commit  = (state_q == ST_COMMIT) &&
			(!status.is_get || !rsp_valid_q || !rsp_stall);
	end

	assign rsp_valid = rsp_valid_q;

	// State and the result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (status.scan_done) begin
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					if (cmd.commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (cmd.commit && status.is_get) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/core/lkv_datapath.sv */
// Datapath of the LFU key/value cache: entry memory, valid bits, scan and update.
// Depends on lkv_pkg; commanded by lkv_ctrl.
module lkv_datapath #(
	parameter int ENTRIES = lkv_pkg::DEFAULT_ENTRIES
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [lkv_pkg::CAP_W-1:0]    cfg_wr_data,
	input  lkv_pkg::req_t                req,
	output lkv_pkg::rsp_t                rsp,
	input  lkv_pkg::cmd_t                cmd,
	output lkv_pkg::status_t             status
);

	localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int USED_W = $clog2(ENTRIES + 1);
	localparam int CAPX_W = (USED_W > lkv_pkg::CAP_W) ? USED_W : lkv_pkg::CAP_W;
	localparam logic [IDX_W-1:0]  LAST_IDX    = IDX_W'(ENTRIES - 1);
	localparam logic [CAPX_W-1:0] ENTRIES_CAP = CAPX_W'(ENTRIES);

	// Entry storage and per-entry valid bits.
	lkv_pkg::entry_t mem [ENTRIES];
	logic [ENTRIES-1:0] valid_q;

	// Configuration, request and clock registers.
	logic [lkv_pkg::CAP_W-1:0]   cap_q;
	lkv_pkg::req_t               req_q;
	logic [lkv_pkg::STAMP_W-1:0] stamp_clock_q;
	lkv_pkg::rsp_t               rsp_q;

	// Read address issue.
	logic             issue_active_q;
	logic [IDX_W-1:0] rd_addr_q;

	// Registered read stage.
	logic             live_s1;
	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;
	lkv_pkg::entry_t  rd_entry_s1;

	// Scan results.
	logic                        match_found_q;
	logic [IDX_W-1:0]            match_idx_q;
	lkv_pkg::entry_t             match_entry_q;
	logic                        victim_found_q;
	logic [IDX_W-1:0]            victim_idx_q;
	logic [lkv_pkg::COUNT_W-1:0] victim_count_q;
	logic [lkv_pkg::STAMP_W-1:0] victim_stamp_q;
	logic                        free_found_q;
	logic [IDX_W-1:0]            free_idx_q;
	logic [USED_W-1:0]           used_q;

	// Commit decisions.
	logic                        is_get;
	logic                        cap_zero;
	logic [CAPX_W-1:0]           cap_ext;
	logic [CAPX_W-1:0]           cap_eff;
	logic                        evict;
	logic [IDX_W-1:0]            slot;
	logic [ENTRIES-1:0]          valid_next;
	logic                        wr_en;
	logic                        wr_new;
	logic [IDX_W-1:0]            wr_addr;
	lkv_pkg::entry_t             wr_data;
	logic [lkv_pkg::STAMP_W-1:0] stamp_next;
	logic [lkv_pkg::COUNT_W-1:0] count_bumped;
	logic                        key_match;
	logic                        older;

	assign is_get   = (req_q.op == lkv_pkg::OP_GET);
	assign cap_zero = (cap_q == '0);
	assign cap_ext  = CAPX_W'(cap_q);
	assign cap_eff  = (cap_ext > ENTRIES_CAP) ? ENTRIES_CAP : cap_ext;

	assign status.scan_done = live_s1 && (idx_s1 == LAST_IDX);
	assign status.is_get    = is_get;
	assign rsp              = rsp_q;

	// Per-entry compare against the running search state.
	assign key_match = vld_s1 && (rd_entry_s1.key == $unsigned(req_q.lookup_key));
	assign older     = !victim_found_q ||
		(rd_entry_s1.count < victim_count_q) ||
		((rd_entry_s1.count == victim_count_q) && (rd_entry_s1.stamp < victim_stamp_q));

	// Update decision: restamp and count a hit (a put also writes its value), or fill a slot for a new key on a put.
	always_comb begin
		stamp_next   = stamp_clock_q + 1'b1;
		count_bumped = (match_entry_q.count == lkv_pkg::COUNT_MAX) ?
			match_entry_q.count : match_entry_q.count + 1'b1;
		evict        = (CAPX_W'(used_q) >= cap_eff) && victim_found_q;
		slot         = evict ?
			((free_found_q && (free_idx_q < victim_idx_q)) ? free_idx_q : victim_idx_q) :
			free_idx_q;
		// The victim is dropped and the chosen slot marked in one update.
		valid_next   = valid_q;
		if (evict) begin
			valid_next[victim_idx_q] = 1'b0;
		end
		valid_next[slot] = 1'b1;
		wr_en        = 1'b0;
		wr_new       = 1'b0;
		wr_addr      = match_idx_q;
		wr_data.key  = $unsigned(req_q.lookup_key);
		wr_data.value = is_get ? match_entry_q.value : $unsigned(req_q.write_value);
		wr_data.count = count_bumped;
		wr_data.stamp = stamp_next;
		if (cmd.commit && !cap_zero) begin
			if (match_found_q) begin
				wr_en = 1'b1;
			end else if (!is_get && (evict || free_found_q)) begin
				wr_en         = 1'b1;
				wr_new        = 1'b1;
				wr_addr       = slot;
				wr_data.count = '0;
			end
		end
	end

	// Entry memory: one registered read and one write a cycle.
	always_ff @(posedge clk) begin
		if (issue_active_q) begin
			rd_entry_s1 <= mem[rd_addr_q];
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
		end
		if (live_s1 && key_match && !match_found_q) begin
			match_idx_q   <= idx_s1;
			match_entry_q <= rd_entry_s1;
		end
		if (live_s1 && vld_s1 && older) begin
			victim_idx_q   <= idx_s1;
			victim_count_q <= rd_entry_s1.count;
			victim_stamp_q <= rd_entry_s1.stamp;
		end
		if (live_s1 && !vld_s1 && !free_found_q) begin
			free_idx_q <= idx_s1;
		end
		if (cmd.commit && is_get) begin
			rsp_q.hit        <= !cap_zero && match_found_q;
			rsp_q.read_value <= (!cap_zero && match_found_q) ?
				$signed(match_entry_q.value) : $signed(lkv_pkg::MISS_VALUE);
		end
	end

	// Control state: configuration, valid bits, clock, scan sequencing and flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q          <= lkv_pkg::CAP_RESET;
			valid_q        <= '0;
			stamp_clock_q  <= '0;
			issue_active_q <= 1'b0;
			rd_addr_q      <= '0;
			live_s1        <= 1'b0;
			vld_s1         <= 1'b0;
			idx_s1         <= '0;
			match_found_q  <= 1'b0;
			victim_found_q <= 1'b0;
			free_found_q   <= 1'b0;
			used_q         <= '0;
		end else begin
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end

			// Issue one read address per cycle across all entries.
			live_s1 <= issue_active_q;
			vld_s1  <= valid_q[rd_addr_q];
			idx_s1  <= rd_addr_q;
			if (cmd.capture) begin
				issue_active_q <= 1'b1;
				rd_addr_q      <= '0;
			end else if (issue_active_q) begin
				if (rd_addr_q == LAST_IDX) begin
					issue_active_q <= 1'b0;
				end else begin
					rd_addr_q <= rd_addr_q + 1'b1;
				end
			end

			// Accumulate match, victim, free slot and occupancy.
			if (cmd.capture) begin
				match_found_q  <= 1'b0;
				victim_found_q <= 1'b0;
				free_found_q   <= 1'b0;
				used_q         <= '0;
			end else if (live_s1) begin
				if (vld_s1) begin
					used_q         <= used_q + 1'b1;
					victim_found_q <= 1'b1;
					if (key_match) begin
						match_found_q <= 1'b1;
					end
				end else begin
					free_found_q <= 1'b1;
				end
			end

			// Commit: valid bits and the stamp clock.
			if (wr_en) begin
				stamp_clock_q <= stamp_next;
			end
			if (wr_new) begin
				valid_q <= valid_next;
			end
		end
	end

endmodule
